### sv/lpc_pkg.sv
// ----------------------------------------------------------------------------
// LRU page cache package
// Shared types and constants of the fully associative LRU page cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int DEF_ENTRIES = 256;
    localparam int KEY_W       = 64;
    localparam int DATA_W      = 64;
    localparam int STAMP_W     = 64;
    localparam int FIELD_W     = 9;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHRINK = 2'd2;
    localparam logic [1:0] OP_GROW   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  payload;
        logic               dirty_in;
        logic [FIELD_W-1:0] amount;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  hit_payload;
        logic               evicted_valid;
        logic [KEY_W-1:0]   evicted_key;
        logic [DATA_W-1:0]  evicted_payload;
        logic               evicted_dirty;
        logic [FIELD_W-1:0] capacity_now;
        logic [FIELD_W-1:0] occupancy;
        logic [63:0]        access_count;
        logic [63:0]        hit_count;
        logic [63:0]        dirty_eviction_count;
    } t_result;

    // One stored page. The stamp orders entries by recency, smallest oldest.
    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
        logic               dirty;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  payload;
    } t_entry;

endpackage

### sv/lru_page_cache_policy.sv
// Fully associative LRU page cache.
// Lookup, insert and an evicting shrink sweep the entry memory once, one entry per
// cycle through its single read port.
// Grow, and insert or shrink that need no sweep, finish directly from the idle state.
// Each result is strobed on o_done for one cycle; the receiver cannot stall.
// After reset a clearing pass over every entry holds busy high.
module lru_page_cache_policy #(
    parameter int ENTRIES = lpc_pkg::DEF_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  lpc_pkg::t_item                     i_item,
    input  logic                               i_cfg_we,
    input  logic [lpc_pkg::FIELD_W-1:0]        i_cfg_data,
    output logic                               o_done,
    output lpc_pkg::t_result                   o_result
);

    localparam int AW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int SW      = ((CW > lpc_pkg::FIELD_W) ? CW : lpc_pkg::FIELD_W) + 1;
    localparam int RST_CAP = (ENTRIES < 256) ? ENTRIES : 256;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cap, n_cap;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [63:0]            r_acc, n_acc;
    logic [63:0]            r_hits, n_hits;
    logic [63:0]            r_dev, n_dev;
    logic [lpc_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic                   r_did_ev, n_did_ev;
    logic                   r_done, n_done;
    lpc_pkg::t_result       r_res, n_res;
    lpc_pkg::t_item         r_item;

    logic [AW-1:0]          r_addr;
    logic                   r_iss;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic                   r_m_ok, r_v_ok, r_f_ok;
    logic [AW-1:0]          r_m_idx, r_v_idx, r_f_idx;
    lpc_pkg::t_entry        r_m_e, r_v_e;

    logic                   rd_en;
    lpc_pkg::t_entry        rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    lpc_pkg::t_entry        wr_data;

    logic                   accept;
    logic                   fin;
    logic                   hit_f;
    logic [lpc_pkg::DATA_W-1:0] hit_p;
    logic                   ev_f;
    logic [SW-1:0]          grow_sum;
    logic [SW-1:0]          cfg_ext;
    logic [AW-1:0]          slot;

    lpc_store #(.ENTRIES(ENTRIES)) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign rd_en    = (r_state == S_SCAN) && r_iss;
    assign o_done   = r_done;
    assign o_result = r_res;
    assign grow_sum = SW'(r_cap) + SW'(i_item.amount);
    assign cfg_ext  = SW'(i_cfg_data);

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_hits   = r_hits;
        n_dev    = r_dev;
        n_stamp  = r_stamp;
        n_did_ev = r_did_ev;
        n_done   = 1'b0;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = '0;
        fin      = 1'b0;
        hit_f    = 1'b0;
        hit_p    = '0;
        ev_f     = 1'b0;
        slot     = r_f_idx;

        case (r_state)
            S_CLR: begin
                wr_en = 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_did_ev = 1'b0;
                if (accept) begin
                    case (i_item.op)
                        lpc_pkg::OP_GROW: begin
                            n_cap = (grow_sum > SW'(ENTRIES)) ? CW'(ENTRIES) : CW'(grow_sum);
                            fin   = 1'b1;
                        end
                        lpc_pkg::OP_INSERT: begin
                            if (r_cap == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        lpc_pkg::OP_SHRINK: begin
                            if (r_cap == '0) begin
                                fin = 1'b1;
                            end else if (r_cnt < r_cap) begin
                                n_cap = r_cap - 1'b1;
                                fin   = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_vld && r_rd_idx == LAST) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (r_item.op == lpc_pkg::OP_LOOKUP) begin
                    n_acc = r_acc + 1'b1;
                    if (r_m_ok) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_m_idx;
                        wr_data       = r_m_e;
                        wr_data.stamp = r_stamp;
                        n_stamp       = r_stamp + 1'b1;
                        n_hits        = r_hits + 1'b1;
                        hit_f         = 1'b1;
                        hit_p         = r_m_e.payload;
                    end
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // Evict the oldest entry when the store is at or over capacity.
                    if (r_cnt >= r_cap && r_v_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = r_v_idx;
                        n_cnt   = r_cnt - 1'b1;
                        ev_f    = 1'b1;
                        if (r_v_e.dirty) begin
                            n_dev = r_dev + 1'b1;
                        end
                    end
                    n_did_ev = ev_f;
                    if (r_item.op == lpc_pkg::OP_SHRINK) begin
                        n_cap   = r_cap - 1'b1;
                        fin     = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WR2;
                    end
                end
            end
            S_WR2: begin
                ev_f = r_did_ev;
                if (r_did_ev && !(r_f_ok && r_f_idx < r_v_idx)) begin
                    slot = r_v_idx;
                end
                if (r_did_ev || r_f_ok) begin
                    wr_en           = 1'b1;
                    wr_addr         = slot;
                    wr_data.valid   = 1'b1;
                    wr_data.stamp   = r_stamp;
                    wr_data.dirty   = r_item.dirty_in;
                    wr_data.key     = r_item.key;
                    wr_data.payload = r_item.payload;
                    n_stamp         = r_stamp + 1'b1;
                    n_cnt           = r_cnt + 1'b1;
                end
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done                     = 1'b1;
            n_res.hit                  = hit_f;
            n_res.hit_payload          = hit_p;
            n_res.evicted_valid        = ev_f;
            n_res.evicted_key          = ev_f ? r_v_e.key : '0;
            n_res.evicted_payload      = ev_f ? r_v_e.payload : '0;
            n_res.evicted_dirty        = ev_f && r_v_e.dirty;
            n_res.capacity_now         = lpc_pkg::FIELD_W'(n_cap);
            n_res.occupancy            = lpc_pkg::FIELD_W'(n_cnt);
            n_res.access_count         = n_acc;
            n_res.hit_count            = n_hits;
            n_res.dirty_eviction_count = n_dev;
        end

        if (i_cfg_we) begin
            n_cap = (cfg_ext > SW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cap    <= CW'(RST_CAP);
            r_cnt    <= '0;
            r_acc    <= '0;
            r_hits   <= '0;
            r_dev    <= '0;
            r_stamp  <= '0;
            r_did_ev <= 1'b0;
            r_done   <= 1'b0;
            r_addr   <= '0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_hits   <= n_hits;
            r_dev    <= n_dev;
            r_stamp  <= n_stamp;
            r_did_ev <= n_did_ev;
            r_done   <= n_done;
            r_rd_vld <= rd_en;
            if (r_state == S_CLR) begin
                r_addr <= r_addr + 1'b1;
            end else if (accept) begin
                r_addr <= '0;
                r_iss  <= 1'b1;
            end else if (rd_en) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == LAST) begin
                    r_iss <= 1'b0;
                end
            end
        end
    end

    // Search results of the sweep: first key match, oldest entry, first free slot.
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_rd_idx <= r_addr;
        if (accept) begin
            r_item <= i_item;
            r_m_ok <= 1'b0;
            r_v_ok <= 1'b0;
            r_f_ok <= 1'b0;
        end else if (r_rd_vld) begin
            if (rd_data.valid && rd_data.key == r_item.key && !r_m_ok) begin
                r_m_ok  <= 1'b1;
                r_m_idx <= r_rd_idx;
                r_m_e   <= rd_data;
            end
            if (rd_data.valid && (!r_v_ok || rd_data.stamp < r_v_e.stamp)) begin
                r_v_ok  <= 1'b1;
                r_v_idx <= r_rd_idx;
                r_v_e   <= rd_data;
            end
            if (!rd_data.valid && !r_f_ok) begin
                r_f_ok  <= 1'b1;
                r_f_idx <= r_rd_idx;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES))
        else $error("entry count above store size");
    a_cap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap <= CW'(ENTRIES))
        else $error("capacity above store size");
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("store read and write in the same cycle");
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> !o_done)
        else $error("result during clearing pass");
`endif

endmodule

### sv/lpc_store.sv
// ----------------------------------------------------------------------------
// LRU page cache entry store
// Single-port-read, single-port-write synchronous memory of page entries.
// ----------------------------------------------------------------------------
module lpc_store #(
    parameter int ENTRIES = lpc_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output lpc_pkg::t_entry            o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  lpc_pkg::t_entry            i_wr_data
);

    lpc_pkg::t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
